// ----- rtl/aoc_pkg.sv -----
// Package of the accelerometer orientation classifier.
// Holds the register map, sequencer states, field widths and fixed constants.
// No dependencies.
package aoc_pkg;

   // Field widths of one request and one result.
   localparam int AXIS_W  = 16;
   localparam int POS_W   = 3;
   localparam int CONF_W  = 16;
   localparam int REQ_W   = 48;
   localparam int RSP_W   = 72;
   localparam int ADDR_W  = 5;
   localparam int DATA_W  = 32;
   localparam int NUM_POS = 6;

   // Shared divider: dividend covers |value * 100| and |ring sum|, divisor a 16 bit magnitude.
   localparam int DVD_W    = 22;
   localparam int DSR_W    = 16;
   localparam int DIV_CNT_W = 5;

   // Multiplier operands and product.
   localparam int MUL_W  = 17;
   localparam int PROD_W = 34;

   // Position codes and fixed levels.
   localparam logic [POS_W-1:0]  POS_NEUTRAL    = 3'd5;
   localparam logic [POS_W-1:0]  POS_UNRESOLVED = 3'd6;
   localparam logic [POS_W-1:0]  POS_LAST       = 3'd5;
   localparam logic [CONF_W-1:0] CONF_MAX      = 16'hFFFF;
   localparam logic [CONF_W-1:0] CONF_NEUTRAL  = 16'd100;
   localparam logic [CONF_W-1:0] CONF_NONE     = 16'd0;
   localparam logic signed [MUL_W-1:0] PERCENT = 17'sd100;
   localparam logic signed [AXIS_W-1:0] FLAT_XY_HI = 16'sd512;
   localparam logic signed [AXIS_W-1:0] FLAT_XY_LO = -16'sd512;
   localparam logic signed [AXIS_W-1:0] FLAT_Z_LO  = 16'sd2000;
   localparam logic signed [AXIS_W-1:0] FLAT_Z_HI  = 16'sd3023;
   localparam logic [15:0] SCALE_RESET = 16'd10048;

   // Axis codes in the axis select register.
   typedef enum logic [1:0] {
      AXIS_X    = 2'd0,
      AXIS_Y    = 2'd1,
      AXIS_Z    = 2'd2,
      AXIS_NONE = 2'd3
   } axis_code_type;

   // Register indexes (byte address is four times the index).
   typedef enum logic [2:0] {
      REG_SCALE = 3'd0,
      REG_THR0  = 3'd1,
      REG_THR1  = 3'd2,
      REG_THR2  = 3'd3,
      REG_THR3  = 3'd4,
      REG_THR4  = 3'd5,
      REG_THR5  = 3'd6,
      REG_AXIS  = 3'd7
   } reg_index_type;

   // Sequencer states, one-hot.
   typedef enum logic [9:0] {
      S_IDLE       = 10'b0000000001,
      S_UPDATE     = 10'b0000000010,
      S_AVG_LOAD   = 10'b0000000100,
      S_DIVIDE     = 10'b0000001000,
      S_AVG_MUL    = 10'b0000010000,
      S_AVG_STORE  = 10'b0000100000,
      S_CONF_MUL   = 10'b0001000000,
      S_CONF_LOAD  = 10'b0010000000,
      S_CONF_CHECK = 10'b0100000000,
      S_OUTPUT     = 10'b1000000000
   } state_type;

endpackage

// ----- rtl/accel_orientation_classifier_core.sv -----
// Accelerometer orientation classifier: moving average, scaling and position vote.
// Depends on aoc_pkg and aoc_ram.
//
// Usage:
// Each request on the req_ stream carries one raw 3-axis sample. The sample
// replaces the oldest entry of a ring of WINDOW samples (all zero after reset),
// the per-axis ring averages are scaled to Q.8 m/s^2, and the six configured
// positions are scored. One result per request leaves on the rsp_ stream.
// The sequencer finishes one request before it accepts the next; its processing
// time grows with the number of positions with a nonzero threshold. The shared
// restoring divider, one quotient bit per cycle over 22 bits, serves the three
// averages and every confidence.
// req_tready is high only while the sequencer is idle. The result sits in an
// output register, so a new request is taken while the result waits; if the
// receiver stalls, the next result holds in the sequencer until the output
// register frees. Reset (synchronous, active high) clears the ring valid bits,
// the running sums, the registers to their reset values and rsp_tvalid. The user
// must write the csr_ APB port only while the block is idle; the block does not enforce it.
module accel_orientation_classifier_core #(
   parameter int WINDOW      = 8,
   parameter int MIN_PERCENT = 70
) (
   input  logic                        clock,
   input  logic                        reset,
   // Request stream.
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // tdata: accel_x [15:0], accel_y [31:16], accel_z [47:32].
   input  logic [aoc_pkg::REQ_W-1:0]   req_tdata,
   // Result stream.
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // tdata: position [2:0], confidence [18:3], proc_x [34:19], proc_y [50:35],
   // proc_z [66:51], zero [71:67].
   output logic [aoc_pkg::RSP_W-1:0]   rsp_tdata,
   // Configuration port.
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [aoc_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [aoc_pkg::DATA_W-1:0]  csr_pwdata,
   output logic [aoc_pkg::DATA_W-1:0]  csr_prdata,
   output logic                        csr_pready
);

   import aoc_pkg::*;

   localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int SUM_W  = AXIS_W + $clog2(WINDOW);
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);
   localparam logic [DSR_W-1:0]  WIN_DIV   = DSR_W'(WINDOW);
   localparam logic [CONF_W-1:0] MIN_CONF  = CONF_W'(MIN_PERCENT);

   // Configuration registers.
   logic [15:0]              scale_ff;
   logic signed [AXIS_W-1:0] thr_ff [NUM_POS];
   logic [11:0]              axis_sel_ff;

   // Sequencer and datapath registers.
   state_type                state_ff, state_in;
   logic [REQ_W-1:0]         sample_ff, sample_in;
   logic [SLOT_W-1:0]        slot_ff, slot_in;
   logic [WINDOW-1:0]        valid_ff, valid_in;
   logic signed [SUM_W-1:0]  sum_ff [3];
   logic signed [SUM_W-1:0]  sum_in [3];
   logic signed [AXIS_W-1:0] proc_ff [3];
   logic signed [AXIS_W-1:0] proc_in [3];
   logic [1:0]               axis_ff, axis_in;
   logic [POS_W-1:0]         pos_ff, pos_in;
   logic                     conf_phase_ff, conf_phase_in;
   logic                     neg_ff, neg_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [DSR_W-1:0]         rem_ff, rem_in;
   logic [DVD_W-1:0]         quo_ff, quo_in;
   logic [DSR_W-1:0]         dsr_ff, dsr_in;
   logic [DIV_CNT_W-1:0]     cnt_ff, cnt_in;
   logic [CONF_W-1:0]        best_ff, best_in;
   logic [POS_W-1:0]         win_ff, win_in;
   logic                     found_ff, found_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]         rsp_data_ff, rsp_data_in;

   // Combinational helpers.
   logic                     req_accept;
   logic                     csr_write;
   reg_index_type            csr_index;
   logic [REQ_W-1:0]         ring_rd_data;
   logic                     ring_wr_en;
   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic [DSR_W:0]           div_shift, div_diff;
   logic                     div_ge;
   logic signed [SUM_W-1:0]  sum_sel;
   logic signed [AXIS_W-1:0] thr_sel;
   logic signed [AXIS_W-1:0] value_sel;
   logic signed [MUL_W-1:0]  avg_val;
   logic [CONF_W-1:0]        conf_sat;
   logic                     out_free;
   logic                     flat;

   assign req_accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = reg_index_type'(csr_paddr[4:2]);
   assign csr_pready = 1'b1;
   assign ring_wr_en = (state_ff == S_UPDATE);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Sample ring memory.
   aoc_ram #(
      .WIDTH (REQ_W),
      .DEPTH (WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_wr_en),
      .wr_addr (slot_ff),
      .wr_data (sample_ff),
      .rd_en   (req_accept),
      .rd_addr (slot_ff),
      .rd_data (ring_rd_data)
   );

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff    <= SCALE_RESET;
         axis_sel_ff <= '0;
         for (int i = 0; i < NUM_POS; i++) begin
            thr_ff[i] <= '0;
         end
      end else if (csr_write) begin
         unique case (csr_index)
            REG_SCALE: scale_ff    <= csr_pwdata[15:0];
            REG_THR0:  thr_ff[0]   <= csr_pwdata[15:0];
            REG_THR1:  thr_ff[1]   <= csr_pwdata[15:0];
            REG_THR2:  thr_ff[2]   <= csr_pwdata[15:0];
            REG_THR3:  thr_ff[3]   <= csr_pwdata[15:0];
            REG_THR4:  thr_ff[4]   <= csr_pwdata[15:0];
            REG_THR5:  thr_ff[5]   <= csr_pwdata[15:0];
            REG_AXIS:  axis_sel_ff <= csr_pwdata[11:0];
         endcase
      end
   end

   // Configuration reads; thresholds read back sign-extended.
   always_comb begin
      unique case (csr_index)
         REG_SCALE: csr_prdata = {16'd0, scale_ff};
         REG_THR0:  csr_prdata = 32'(thr_ff[0]);
         REG_THR1:  csr_prdata = 32'(thr_ff[1]);
         REG_THR2:  csr_prdata = 32'(thr_ff[2]);
         REG_THR3:  csr_prdata = 32'(thr_ff[3]);
         REG_THR4:  csr_prdata = 32'(thr_ff[4]);
         REG_THR5:  csr_prdata = 32'(thr_ff[5]);
         REG_AXIS:  csr_prdata = {20'd0, axis_sel_ff};
      endcase
   end

   // Operand selection for the current axis and position.
   always_comb begin
      sum_sel = sum_ff[axis_ff];
      thr_sel = thr_ff[pos_ff];
      unique case (axis_code_type'(axis_sel_ff[{pos_ff, 1'b0} +: 2]))
         AXIS_X:    value_sel = proc_ff[0];
         AXIS_Y:    value_sel = proc_ff[1];
         AXIS_Z:    value_sel = proc_ff[2];
         AXIS_NONE: value_sel = '0;
      endcase
      avg_val = neg_ff ? -$signed({1'b0, quo_ff[MUL_W-2:0]}) : $signed({1'b0, quo_ff[MUL_W-2:0]});
   end

   // Shared multiplier: average times scale, or axis value times one hundred.
   always_comb begin
      if (state_ff == S_AVG_MUL) begin
         mul_a = avg_val;
         mul_b = $signed({1'b0, scale_ff});
      end else begin
         mul_a = MUL_W'(value_sel);
         mul_b = PERCENT;
      end
   end

   // Restoring divider step, one quotient bit per cycle.
   assign div_shift = {rem_ff, quo_ff[DVD_W-1]};
   assign div_diff  = div_shift - {1'b0, dsr_ff};
   assign div_ge    = (div_shift >= {1'b0, dsr_ff});

   // Saturated confidence and the flat test.
   assign conf_sat = (|quo_ff[DVD_W-1:CONF_W]) ? CONF_MAX : quo_ff[CONF_W-1:0];
   assign flat = (proc_ff[0] > FLAT_XY_LO) && (proc_ff[0] < FLAT_XY_HI) &&
                 (proc_ff[1] > FLAT_XY_LO) && (proc_ff[1] < FLAT_XY_HI) &&
                 (proc_ff[2] >= FLAT_Z_LO) && (proc_ff[2] <= FLAT_Z_HI);

   // Sequencer and datapath next values.
   always_comb begin
      logic signed [SUM_W-1:0]  old_s;
      logic [SUM_W-1:0]         sum_mag;
      logic [PROD_W-1:0]        prod_mag;
      logic [POS_W-1:0]         fin_pos;
      logic [CONF_W-1:0]        fin_conf;

      state_in      = state_ff;
      sample_in     = sample_ff;
      slot_in       = slot_ff;
      valid_in      = valid_ff;
      sum_in        = sum_ff;
      proc_in       = proc_ff;
      axis_in       = axis_ff;
      pos_in        = pos_ff;
      conf_phase_in = conf_phase_ff;
      neg_in        = neg_ff;
      prod_in       = prod_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      dsr_in        = dsr_ff;
      cnt_in        = cnt_ff;
      best_in       = best_ff;
      win_in        = win_ff;
      found_in      = found_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      sum_mag       = sum_sel[SUM_W-1] ? SUM_W'(-sum_sel) : SUM_W'(sum_sel);
      prod_mag      = prod_ff[PROD_W-1] ? PROD_W'(-prod_ff) : PROD_W'(prod_ff);
      old_s         = '0;

      // Final position: best qualified vote, else neutral when flat, else unresolved.
      if (found_ff) begin
         fin_pos  = win_ff;
         fin_conf = best_ff;
      end else if (flat) begin
         fin_pos  = POS_NEUTRAL;
         fin_conf = CONF_NEUTRAL;
      end else begin
         fin_pos  = POS_UNRESOLVED;
         fin_conf = CONF_NONE;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               sample_in = req_tdata;
               state_in  = S_UPDATE;
            end
         end
         // Running sums: add the new sample, drop the one it overwrites.
         S_UPDATE: begin
            for (int a = 0; a < 3; a++) begin
               old_s = valid_ff[slot_ff] ?
                       SUM_W'($signed(ring_rd_data[a*AXIS_W +: AXIS_W])) : '0;
               sum_in[a] = sum_ff[a] + SUM_W'($signed(sample_ff[a*AXIS_W +: AXIS_W]))
                           - old_s;
            end
            valid_in[slot_ff] = 1'b1;
            slot_in       = (slot_ff == SLOT_LAST) ? '0 : slot_ff + 1'b1;
            axis_in       = '0;
            conf_phase_in = 1'b0;
            state_in      = S_AVG_LOAD;
         end
         S_AVG_LOAD: begin
            neg_in   = sum_sel[SUM_W-1];
            rem_in   = '0;
            quo_in   = DVD_W'(sum_mag);
            dsr_in   = WIN_DIV;
            cnt_in   = DIV_CNT_W'(DVD_W - 1);
            state_in = S_DIVIDE;
         end
         S_DIVIDE: begin
            rem_in = div_ge ? div_diff[DSR_W-1:0] : div_shift[DSR_W-1:0];
            quo_in = {quo_ff[DVD_W-2:0], div_ge};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = conf_phase_ff ? S_CONF_CHECK : S_AVG_MUL;
            end
         end
         S_AVG_MUL: begin
            prod_in  = mul_a * mul_b;
            state_in = S_AVG_STORE;
         end
         // Floor shift by 16: bits 31:16 of the product.
         S_AVG_STORE: begin
            proc_in[axis_ff] = prod_ff[31:16];
            if (axis_ff == 2'd2) begin
               pos_in        = '0;
               best_in       = '0;
               found_in      = 1'b0;
               win_in        = POS_UNRESOLVED;
               conf_phase_in = 1'b1;
               state_in      = S_CONF_MUL;
            end else begin
               axis_in  = axis_ff + 1'b1;
               state_in = S_AVG_LOAD;
            end
         end
         // Positions with a zero threshold are skipped.
         S_CONF_MUL: begin
            prod_in = mul_a * mul_b;
            if (thr_sel != '0) begin
               state_in = S_CONF_LOAD;
            end else if (pos_ff == POS_LAST) begin
               state_in = S_OUTPUT;
            end else begin
               pos_in = pos_ff + 1'b1;
            end
         end
         // A quotient counts only when dividend and divisor share a sign.
         S_CONF_LOAD: begin
            neg_in   = prod_ff[PROD_W-1] ^ thr_sel[AXIS_W-1];
            rem_in   = '0;
            quo_in   = prod_mag[DVD_W-1:0];
            dsr_in   = thr_sel[AXIS_W-1] ? DSR_W'(-thr_sel) : DSR_W'(thr_sel);
            cnt_in   = DIV_CNT_W'(DVD_W - 1);
            state_in = S_DIVIDE;
         end
         S_CONF_CHECK: begin
            if (!neg_ff && (conf_sat >= MIN_CONF) && (conf_sat > best_ff)) begin
               best_in  = conf_sat;
               win_in   = pos_ff;
               found_in = 1'b1;
            end
            if (pos_ff == POS_LAST) begin
               state_in = S_OUTPUT;
            end else begin
               pos_in   = pos_ff + 1'b1;
               state_in = S_CONF_MUL;
            end
         end
         // Hand the result to the output register once it is free.
         S_OUTPUT: begin
            if (out_free) begin
               rsp_data_in  = {5'd0, proc_ff[2], proc_ff[1], proc_ff[0], fin_conf, fin_pos};
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         slot_ff      <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int a = 0; a < 3; a++) begin
            sum_ff[a] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         sum_ff       <= sum_in;
      end
   end

   // Payload and working registers.
   always_ff @(posedge clock) begin
      sample_ff     <= sample_in;
      proc_ff       <= proc_in;
      axis_ff       <= axis_in;
      pos_ff        <= pos_in;
      conf_phase_ff <= conf_phase_in;
      neg_ff        <= neg_in;
      prod_ff       <= prod_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      dsr_ff        <= dsr_in;
      cnt_ff        <= cnt_in;
      best_ff       <= best_in;
      win_ff        <= win_in;
      found_ff      <= found_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   // An accepted request always starts with the ring update.
   a_accept_update: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == S_UPDATE))
      else $error("accepted request did not enter the ring update");

   // A recorded winner always meets the minimum confidence.
   a_best_min: assert property (@(posedge clock) disable iff (reset)
      (found_ff && (state_ff == S_OUTPUT)) |-> (best_ff >= MIN_CONF))
      else $error("winning confidence below the minimum");

   // A new result never overwrites one still waiting at the output.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> (rsp_valid_ff && $stable(rsp_data_ff)))
      else $error("waiting result was overwritten");

   // Unresolved position comes with zero confidence and nothing else does.
   a_unresolved_conf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_data_ff[POS_W-1:0] == POS_UNRESOLVED) ==
                        (rsp_data_ff[POS_W +: CONF_W] == CONF_NONE)))
      else $error("unresolved position and zero confidence disagree");
`endif

endmodule

// ----- rtl/aoc_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the sample ring of the orientation classifier; no dependencies.
module aoc_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 8
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for accel_orientation_classifier_core: raw samples and register writes
// are driven, every result is predicted by a scoreboard and compared field by field.
// Depends on aoc_pkg and the accel_orientation_classifier_core RTL.
module tb_top;
   import aoc_pkg::*;

   localparam int WINDOW        = 8;
   localparam int MIN_PERCENT   = 70;
   localparam int STALL_LIMIT   = 5000;
   localparam int HOLD_CYCLES   = 600;
   localparam int SETTLE_CYCLES = 300;
   localparam int ROUNDS        = 10;
   localparam int ROUND_ITEMS   = 103;
   localparam int ONE_G         = 16384;
   localparam int G_LEVEL       = 2511;
   // Positions 0..5 look at +X, -X, +Y, -Y, +Z, -Z of the usual layout.
   localparam logic [11:0] ORIENT_AXES = {AXIS_Z, AXIS_Z, AXIS_Y, AXIS_Y, AXIS_X, AXIS_X};

   // One result as it leaves the rsp_ stream.
   typedef struct packed {
      logic [POS_W-1:0]         position;
      logic [CONF_W-1:0]        confidence;
      logic signed [AXIS_W-1:0] proc_x;
      logic signed [AXIS_W-1:0] proc_y;
      logic signed [AXIS_W-1:0] proc_z;
   } orient_report_type;

   // Scoreboard: its own copy of the sample ring and registers, and the queue of
   // reports still owed by the block.
   class orientation_scoreboard;
      logic signed [15:0] ring [WINDOW][3];
      int unsigned        write_slot;
      logic [15:0]        scale_factor;
      logic signed [15:0] thresholds [NUM_POS];
      logic [11:0]        axis_select;
      orient_report_type  expected_reports [$];
      int unsigned        failures;

      function new();
         foreach (ring[i, a]) ring[i][a] = '0;
         foreach (thresholds[p]) thresholds[p] = '0;
         write_slot   = 0;
         scale_factor = SCALE_RESET;
         axis_select  = '0;
         failures     = 0;
      endfunction

      // Mirrors one accepted register write; bits above the register width are dropped.
      function void write_reg(reg_index_type idx, logic [31:0] value);
         case (idx)
            REG_SCALE: scale_factor = value[15:0];
            REG_AXIS:  axis_select = value[11:0];
            default:   thresholds[int'(idx) - int'(REG_THR0)] = value[15:0];
         endcase
      endfunction

      // Stores the sample, averages the ring, scales it and votes on a position.
      function orient_report_type classify_sample(logic [REQ_W-1:0] word);
         orient_report_type  r;
         logic signed [15:0] proc_axis [3];
         logic signed [15:0] value;
         axis_code_type      code;
         int                 sum;
         int                 avg;
         longint             prod;
         longint             conf;
         longint             best;
         logic [POS_W-1:0]   pos;
         ring[write_slot][0] = word[15:0];
         ring[write_slot][1] = word[31:16];
         ring[write_slot][2] = word[47:32];
         write_slot = (write_slot + 1) % WINDOW;
         // Averages truncate toward zero, the scaling shift floors.
         for (int a = 0; a < 3; a++) begin
            sum = 0;
            for (int i = 0; i < WINDOW; i++) sum += ring[i][a];
            avg  = sum / WINDOW;
            prod = longint'(avg) * longint'(scale_factor);
            prod = prod >>> 16;
            proc_axis[a] = prod[15:0];
         end
         // First strictly best saturated confidence at or above the minimum wins.
         best = 0;
         pos  = POS_UNRESOLVED;
         for (int p = 0; p < NUM_POS; p++) begin
            if (thresholds[p] != 0) begin
               code  = axis_code_type'(axis_select[2*p +: 2]);
               value = (code == AXIS_NONE) ? 16'sd0 : proc_axis[int'(code)];
               conf  = (longint'(value) * 100) / longint'(thresholds[p]);
               if (conf > longint'(CONF_MAX)) conf = longint'(CONF_MAX);
               if (conf >= MIN_PERCENT && conf > best) begin
                  best = conf;
                  pos  = p[POS_W-1:0];
               end
            end
         end
         r.position   = pos;
         r.confidence = best[15:0];
         // No position qualified: near flat is neutral, anything else unresolved.
         if (best < MIN_PERCENT) begin
            if (proc_axis[0] > FLAT_XY_LO && proc_axis[0] < FLAT_XY_HI &&
                proc_axis[1] > FLAT_XY_LO && proc_axis[1] < FLAT_XY_HI &&
                proc_axis[2] >= FLAT_Z_LO && proc_axis[2] <= FLAT_Z_HI) begin
               r.position   = POS_NEUTRAL;
               r.confidence = CONF_NEUTRAL;
            end else begin
               r.position   = POS_UNRESOLVED;
               r.confidence = CONF_NONE;
            end
         end
         r.proc_x = proc_axis[0];
         r.proc_y = proc_axis[1];
         r.proc_z = proc_axis[2];
         return r;
      endfunction

      function void note_sample(logic [REQ_W-1:0] word);
         expected_reports.push_back(classify_sample(word));
      endfunction

      function void check_report(logic [RSP_W-1:0] word);
         orient_report_type got;
         orient_report_type want;
         got.position   = word[2:0];
         got.confidence = word[18:3];
         got.proc_x     = word[34:19];
         got.proc_y     = word[50:35];
         got.proc_z     = word[66:51];
         if (expected_reports.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected report: pos %0d conf %0d x %0d y %0d z %0d",
                        got.position, got.confidence, got.proc_x, got.proc_y, got.proc_z);
            return;
         end
         want = expected_reports.pop_front();
         if (got !== want) begin
            failures++;
            if (failures <= 10)
               $display({"report mismatch at %0t: expected pos %0d conf %0d x %0d y %0d ",
                         "z %0d, got pos %0d conf %0d x %0d y %0d z %0d"},
                        $time, want.position, want.confidence, want.proc_x, want.proc_y,
                        want.proc_z, got.position, got.confidence, got.proc_x,
                        got.proc_y, got.proc_z);
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata;
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [RSP_W-1:0]  rsp_tdata;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [ADDR_W-1:0] csr_paddr;
   logic [DATA_W-1:0] csr_pwdata;
   logic [DATA_W-1:0] csr_prdata;
   logic              csr_pready;

   orientation_scoreboard board;
   bit                    steady_flow;
   bit                    hold_request;
   int                    stall_cycles;

   accel_orientation_classifier_core #(
      .WINDOW      (WINDOW),
      .MIN_PERCENT (MIN_PERCENT)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Receiver: random stalls, none during the steady stretch, and one long hold-off.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end else begin
            rsp_tready <= steady_flow || ($urandom_range(0, 99) >= 33);
         end
      end
   end

   // Every accepted result is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_report(rsp_tdata);
   end

   // Watchdog: ends the run when nothing moves for too long.
   initial begin
      stall_cycles = 0;
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
            stall_cycles = 0;
         else
            stall_cycles++;
      end
      $display("accel_orientation_classifier_core regression: fail");
      $finish;
   end

   // APB write: setup cycle, then access cycle; called at a falling edge.
   task automatic write_csr(reg_index_type idx, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      board.write_reg(idx, value);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   // Offers one sample request and returns at the falling edge after it is taken.
   task automatic send_sample(logic [15:0] x, logic [15:0] y, logic [15:0] z);
      while (!steady_flow && $urandom_range(0, 99) < 33) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {z, y, x};
      do @(posedge clock); while (!req_tready);
      board.note_sample({z, y, x});
      @(negedge clock);
   endtask

   // Stops offering requests until every predicted report has come back.
   task automatic drain_reports();
      req_tvalid <= 1'b0;
      while (board.expected_reports.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_orientation_config();
      write_csr(REG_SCALE, {16'($urandom), SCALE_RESET});
      for (int p = 0; p < NUM_POS; p++)
         write_csr(reg_index_type'(int'(REG_THR0) + p),
                   {16'($urandom), (p % 2 == 0) ? 16'(G_LEVEL) : 16'(-G_LEVEL)});
      write_csr(REG_AXIS, {20'($urandom), ORIENT_AXES});
   endtask

   // Random settings, with the scale and threshold extremes drawn now and then.
   task automatic randomize_config();
      int          pick;
      logic [15:0] scale;
      logic [15:0] thr;
      pick = $urandom_range(0, 9);
      if (pick < 2)      scale = 16'd0;
      else if (pick < 4) scale = 16'hFFFF;
      else if (pick < 7) scale = SCALE_RESET;
      else               scale = 16'($urandom);
      write_csr(REG_SCALE, {16'($urandom), scale});
      for (int p = 0; p < NUM_POS; p++) begin
         pick = $urandom_range(0, 99);
         if (pick < 20)      thr = 16'd0;
         else if (pick < 60) thr = 16'($urandom_range(1500, 3500));
         else if (pick < 70) thr = 16'($urandom_range(1, 20));
         else if (pick < 75) thr = pick[0] ? 16'h7FFF : 16'h8000;
         else                thr = 16'($urandom);
         if (pick < 70 && $urandom_range(0, 1) == 1) thr = -thr;
         write_csr(reg_index_type'(int'(REG_THR0) + p), {16'($urandom), thr});
      end
      if ($urandom_range(0, 3) != 0)
         write_csr(REG_AXIS, {20'($urandom), ORIENT_AXES});
      else
         write_csr(REG_AXIS, $urandom);
   endtask

   // One run of samples: mostly a held orientation with jitter, sometimes noise
   // or a short broken run.
   task automatic send_random_run(inout int sent);
      int shape;
      int run_len;
      int gx, gy, gz;
      shape   = $urandom_range(0, 9);
      run_len = $urandom_range(4, 16);
      gx = 0;
      gy = 0;
      gz = 0;
      case (shape)
         0, 1, 2, 3, 4, 5: begin
            if (shape / 2 == 0)      gx = (shape % 2 == 0) ? ONE_G : -ONE_G;
            else if (shape / 2 == 1) gy = (shape % 2 == 0) ? ONE_G : -ONE_G;
            else                     gz = (shape % 2 == 0) ? ONE_G : -ONE_G;
         end
         6: begin
            gx = $urandom_range(0, 6000) - 3000;
            gy = $urandom_range(0, 6000) - 3000;
            gz = ONE_G - $urandom_range(0, 3000);
         end
         7: begin
            gx = $urandom_range(0, 2 * ONE_G) - ONE_G;
            gy = $urandom_range(0, 2 * ONE_G) - ONE_G;
            gz = $urandom_range(0, 2 * ONE_G) - ONE_G;
            run_len = $urandom_range(1, 3);
         end
         default: run_len = $urandom_range(1, 3);
      endcase
      for (int i = 0; i < run_len; i++) begin
         if (shape >= 8) begin
            if ($urandom_range(0, 4) == 0)
               send_sample($urandom_range(0, 1) ? 16'h7FFF : 16'h8000,
                           $urandom_range(0, 1) ? 16'h7FFF : 16'h8000,
                           $urandom_range(0, 1) ? 16'h7FFF : 16'h8000);
            else
               send_sample(16'($urandom), 16'($urandom), 16'($urandom));
         end else begin
            send_sample(16'(gx + $urandom_range(0, 800) - 400),
                        16'(gy + $urandom_range(0, 800) - 400),
                        16'(gz + $urandom_range(0, 800) - 400));
         end
         sent++;
      end
   endtask

   // Main sequence: reset, directed requests, then random rounds with new settings.
   initial begin
      int sent;
      board        = new();
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      csr_psel     = 1'b0;
      csr_penable  = 1'b0;
      csr_pwrite   = 1'b0;
      csr_paddr    = '0;
      csr_pwdata   = '0;
      steady_flow  = 1'b0;
      hold_request = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings: field extremes, then a flat board settles to neutral.
      send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_sample(16'h8000, 16'h8000, 16'h8000);
      repeat (8) send_sample(16'd0, 16'd0, 16'(ONE_G));
      drain_reports();

      // Full scale, two saturating positions that tie, a disabled axis, negative ratios.
      write_csr(REG_SCALE, 32'hA5A5_FFFF);
      write_csr(REG_THR0, 32'h1234_0001);
      write_csr(REG_THR1, 32'h0000_0001);
      write_csr(REG_THR2, 32'hFFFF_0064);
      write_csr(REG_THR3, 32'h0000_FFFF);
      write_csr(REG_THR4, 32'h0000_7FFF);
      write_csr(REG_THR5, 32'h0000_8000);
      write_csr(REG_AXIS, {20'hFFFFF, AXIS_Z, AXIS_Z, AXIS_Y, AXIS_NONE, AXIS_X, AXIS_X});
      repeat (4) send_sample(16'h7FFF, 16'd20000, 16'h8000);
      repeat (2) send_sample(16'h8000, 16'h8000, 16'h7FFF);
      drain_reports();

      // Usual orientation settings, board held on its side.
      write_orientation_config();
      repeat (8) send_sample(16'(-ONE_G), 16'd0, 16'd0);
      drain_reports();

      // Random rounds.
      for (int round = 0; round < ROUNDS; round++) begin
         if (round > 1) randomize_config();
         steady_flow = (round == 3);
         if (round == 1) hold_request = 1'b1;
         sent = 0;
         while (sent < ROUND_ITEMS) begin
            send_random_run(sent);
            if (round == 6 && sent >= ROUND_ITEMS / 2 && sent < ROUND_ITEMS / 2 + 4)
               drain_reports();
         end
         drain_reports();
      end
      steady_flow = 1'b0;

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.failures == 0 && board.expected_reports.size() == 0)
         $display("accel_orientation_classifier_core regression: pass");
      else
         $display("accel_orientation_classifier_core regression: fail");
      $finish;
   end

endmodule
